// File: rtl/prenv_pkg.sv
// Shared types, codes and constants of the PCM peak and RMS envelope follower.
package prenv_pkg;

    localparam int DEF_MAX_CHANNELS     = 16;
    localparam int DEF_MAX_CHUNK_FRAMES = 4096;

    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_S32 = 2'd2;
    localparam logic [1:0] FMT_F32 = 2'd3;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic KIND_PEAK = 1'b0;
    localparam logic KIND_RMS  = 1'b1;

    localparam logic [1:0] REG_FORMAT   = 2'd0;
    localparam logic [1:0] REG_CHANNELS = 2'd1;
    localparam logic [1:0] REG_PEAK_LEN = 2'd2;
    localparam logic [1:0] REG_RMS_LEN  = 2'd3;

    localparam logic [1:0]  RST_FORMAT   = FMT_S16;
    localparam logic [4:0]  RST_CHANNELS = 5'd2;
    localparam logic [12:0] RST_PEAK_LEN = 13'd256;
    localparam logic [12:0] RST_RMS_LEN  = 13'd1024;

    localparam logic [15:0] Q15_ONE   = 16'h8000;
    localparam int          MIN_RMS_LEN = 64;

    // The mean of squared Q15 values never exceeds 2^30, so 32 bits and 16 root steps do.
    localparam int MEAN_W     = 32;
    localparam int ROOT_STEPS = MEAN_W / 2;

    typedef struct packed {
        logic take;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic sel_rms;
    } prenv_cmd_t;

    typedef struct packed {
        logic pend_pk;
        logic pend_lv;
        logic div_last;
        logic sqrt_last;
    } prenv_status_t;

endpackage

// File: rtl/pcm_peak_rms_envelope.sv
// Top level of the PCM peak and RMS envelope follower.
// Takes one sample or finish beat at a time on the s_ side and emits chunk peak (tuser 0)
// and RMS level (tuser 1) beats on the m_ side, tlast on the last beat an input beat causes.
// A sample that closes no chunk passes through the decide state back to idle; a chunk peak
// adds its output beat. An RMS result adds the restoring divider (one quotient bit per
// cycle), a setup state and the bit-pair square root before its beats.
// Configuration beats are always taken and must be sent while no sample is in flight.
module pcm_peak_rms_envelope
#(
    parameter int MAX_CHANNELS     = prenv_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_CHUNK_FRAMES = prenv_pkg::DEF_MAX_CHUNK_FRAMES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample_bits
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] level
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import prenv_pkg::*;

    prenv_cmd_t    cmd;
    prenv_status_t status;

    assign cfg_ready = 1'b1;

    prenv_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    prenv_dp
    #(
        .MAX_CHANNELS     (MAX_CHANNELS),
        .MAX_CHUNK_FRAMES (MAX_CHUNK_FRAMES)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (s_tuser),
        .sample_bits (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .level       (m_tdata)
    );

    a_no_intake_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result beat is pending");

    a_rms_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_RMS)) |-> m_tlast)
        else $error("rms beat not marked last");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat taken without processing");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata <= Q15_ONE))
        else $error("level above Q15 full scale");

endmodule

// File: rtl/prenv_ctrl.sv
// Sequencer of the envelope follower: intake, divide, root and result beats.
module prenv_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic                    m_tuser,
    output logic                    m_tlast,
    input  prenv_pkg::prenv_status_t status,
    output prenv_pkg::prenv_cmd_t    cmd
);
    import prenv_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_RINIT  = 3'd3;
    localparam logic [2:0] S_ROOT   = 3'd4;
    localparam logic [2:0] S_OUT_PK = 3'd5;
    localparam logic [2:0] S_OUT_LV = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                priority if (status.pend_lv)
                    state_next = S_DIV;
                else if (status.pend_pk)
                    state_next = S_OUT_PK;
                else
                    state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (status.div_last)
                    state_next = S_RINIT;
            end
            S_RINIT:
                state_next = S_ROOT;
            S_ROOT:
            begin
                if (status.sqrt_last)
                    state_next = status.pend_pk ? S_OUT_PK : S_OUT_LV;
            end
            S_OUT_PK:
            begin
                if (m_tready)
                    state_next = status.pend_lv ? S_OUT_LV : S_IDLE;
            end
            S_OUT_LV:
            begin
                if (m_tready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready      = (state_reg == S_IDLE);
    assign m_tvalid      = (state_reg == S_OUT_PK) || (state_reg == S_OUT_LV);
    assign m_tuser       = (state_reg == S_OUT_LV) ? KIND_RMS : KIND_PEAK;
    assign m_tlast       = (state_reg == S_OUT_LV) || !status.pend_lv;
    assign cmd.take      = s_tready && s_tvalid;
    assign cmd.div_step  = (state_reg == S_DIV);
    assign cmd.sqrt_init = (state_reg == S_RINIT);
    assign cmd.sqrt_step = (state_reg == S_ROOT);
    assign cmd.sel_rms   = (state_reg == S_OUT_LV);

endmodule

// File: rtl/prenv_dp.sv
// Datapath: configuration, sample magnitude, frame and chunk accumulators, divider and root.
module prenv_dp
#(
    parameter int MAX_CHANNELS     = prenv_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_CHUNK_FRAMES = prenv_pkg::DEF_MAX_CHUNK_FRAMES
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic [1:0]               cfg_index,
    input  logic [12:0]              cfg_data,
    input  logic                     op,
    input  logic [31:0]              sample_bits,
    input  prenv_pkg::prenv_cmd_t    cmd,
    output prenv_pkg::prenv_status_t status,
    output logic [15:0]              level
);
    import prenv_pkg::*;

    localparam int CIW = $clog2(MAX_CHANNELS + 1);
    localparam int CT  = (CIW > 5) ? CIW : 5;
    localparam int CW  = $clog2(MAX_CHUNK_FRAMES + 1);
    localparam int TW  = (CW > 13) ? CW : 13;
    localparam int SW  = 30 + CW;
    localparam int DCW = $clog2(SW);

    logic [1:0]  fmt_reg;
    logic [4:0]  chans_cfg_reg;
    logic [12:0] pk_cfg_reg;
    logic [12:0] lv_cfg_reg;

    logic [CIW-1:0] idx_reg;
    logic [15:0]    fpeak_reg;
    logic [CW-1:0]  pfc_reg;
    logic [15:0]    cmax_reg;
    logic [CW-1:0]  lfc_reg;
    logic [SW-1:0]  sum_reg;
    logic           pend_pk_reg;
    logic           pend_lv_reg;
    logic [15:0]    peak_val_reg;

    logic [SW-1:0]  quo_reg;
    logic [CW-1:0]  rem_reg;
    logic [CW-1:0]  dvs_reg;
    logic [DCW-1:0] dcnt_reg;

    logic [MEAN_W-1:0] rop_reg;
    logic [17:0]       rrem_reg;
    logic [15:0]       root_reg;
    logic [3:0]        rcnt_reg;

    // Sample magnitude.
    logic        mag_ok;
    logic [15:0] mag;

    always_comb
    begin
        logic [7:0]  b;
        logic [7:0]  d;
        logic [31:0] a;
        logic [7:0]  e;
        logic [23:0] sig;
        logic [7:0]  sh;
        b      = sample_bits[7:0];
        d      = b[7] ? {1'b0, b[6:0]} : (8'd128 - b);
        a      = sample_bits[31] ? (32'd0 - sample_bits) : sample_bits;
        e      = sample_bits[30:23];
        sig    = {1'b1, sample_bits[22:0]};
        sh     = 8'd135 - e;
        mag_ok = 1'b1;
        mag    = '0;
        unique case (fmt_reg)
            FMT_U8:  mag = {d, 8'h00};
            FMT_S16: mag = sample_bits[15] ? 16'(17'h10000 - {1'b0, sample_bits[15:0]})
                                           : sample_bits[15:0];
            FMT_S32: mag = a[31:16];
            FMT_F32:
            begin
                priority if (e == 8'hFF)
                    mag_ok = 1'b0;
                else if (e == 8'h00)
                    mag = '0;
                else if (e >= 8'd127)
                    mag = Q15_ONE;
                else if (sh >= 8'd32)
                    mag = '0;
                else
                    mag = 16'(sig >> sh);
            end
            default: mag = '0;
        endcase
    end

    // Clamped limits.
    logic [CT-1:0] chans;
    logic [TW-1:0] pk_lim;
    logic [TW-1:0] lv_lim;

    always_comb
    begin
        logic [CT-1:0] c;
        logic [TW-1:0] p;
        logic [TW-1:0] l;
        c = CT'(chans_cfg_reg);
        p = TW'(pk_cfg_reg);
        l = TW'(lv_cfg_reg);
        priority if (c < CT'(1))
            chans = CT'(1);
        else if (c > CT'(MAX_CHANNELS))
            chans = CT'(MAX_CHANNELS);
        else
            chans = c;
        priority if (p < TW'(1))
            pk_lim = TW'(1);
        else if (p > TW'(MAX_CHUNK_FRAMES))
            pk_lim = TW'(MAX_CHUNK_FRAMES);
        else
            pk_lim = p;
        priority if (l < TW'(MIN_RMS_LEN))
            lv_lim = TW'(MIN_RMS_LEN);
        else if (l > TW'(MAX_CHUNK_FRAMES))
            lv_lim = TW'(MAX_CHUNK_FRAMES);
        else
            lv_lim = l;
    end

    // Next stream state for an accepted sample.
    logic [15:0]    fp_new;
    logic [CIW-1:0] idx_inc;
    logic           frame_done;
    logic [15:0]    cm_new;
    logic [CW-1:0]  pfc_inc;
    logic [CW-1:0]  lfc_inc;
    logic [31:0]    fp_sq;
    logic [SW-1:0]  sum_new;
    logic           pk_done;
    logic           lv_done;

    assign fp_new     = (mag_ok && (mag > fpeak_reg)) ? mag : fpeak_reg;
    assign idx_inc    = idx_reg + CIW'(1);
    assign frame_done = (CT'(idx_inc) >= chans);
    assign cm_new     = (fp_new > cmax_reg) ? fp_new : cmax_reg;
    assign pfc_inc    = pfc_reg + CW'(1);
    assign lfc_inc    = lfc_reg + CW'(1);
    assign fp_sq      = fp_new * fp_new;
    assign sum_new    = sum_reg + SW'(fp_sq);
    assign pk_done    = (TW'(pfc_inc) >= pk_lim);
    assign lv_done    = (TW'(lfc_inc) >= lv_lim);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= RST_FORMAT;
            chans_cfg_reg <= RST_CHANNELS;
            pk_cfg_reg    <= RST_PEAK_LEN;
            lv_cfg_reg    <= RST_RMS_LEN;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FORMAT:   fmt_reg       <= cfg_data[1:0];
                REG_CHANNELS: chans_cfg_reg <= cfg_data[4:0];
                REG_PEAK_LEN: pk_cfg_reg    <= cfg_data;
                REG_RMS_LEN:  lv_cfg_reg    <= cfg_data;
                default:      fmt_reg       <= fmt_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            fpeak_reg   <= '0;
            pfc_reg     <= '0;
            cmax_reg    <= '0;
            lfc_reg     <= '0;
            sum_reg     <= '0;
            pend_pk_reg <= 1'b0;
            pend_lv_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            if (op == OP_FINISH)
            begin
                pend_pk_reg <= (pfc_reg != '0);
                pend_lv_reg <= (lfc_reg != '0);
                idx_reg     <= '0;
                fpeak_reg   <= '0;
                pfc_reg     <= '0;
                cmax_reg    <= '0;
                lfc_reg     <= '0;
                sum_reg     <= '0;
            end
            else if (!frame_done)
            begin
                pend_pk_reg <= 1'b0;
                pend_lv_reg <= 1'b0;
                idx_reg     <= idx_inc;
                fpeak_reg   <= fp_new;
            end
            else
            begin
                idx_reg     <= '0;
                fpeak_reg   <= '0;
                pend_pk_reg <= pk_done;
                pend_lv_reg <= lv_done;
                pfc_reg     <= pk_done ? '0 : pfc_inc;
                cmax_reg    <= pk_done ? '0 : cm_new;
                lfc_reg     <= lv_done ? '0 : lfc_inc;
                sum_reg     <= lv_done ? '0 : sum_new;
            end
        end
    end

    // Captured results and the divider operands.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            rem_reg  <= '0;
            dcnt_reg <= '0;
            if (op == OP_FINISH)
            begin
                peak_val_reg <= cmax_reg;
                quo_reg      <= sum_reg;
                dvs_reg      <= lfc_reg;
            end
            else
            begin
                peak_val_reg <= cm_new;
                quo_reg      <= sum_new;
                dvs_reg      <= lfc_inc;
            end
        end
        else if (cmd.div_step)
        begin
            logic [CW:0] r2;
            logic        qbit;
            r2   = {rem_reg, quo_reg[SW-1]};
            qbit = (r2 >= {1'b0, dvs_reg});
            rem_reg  <= qbit ? CW'(r2 - {1'b0, dvs_reg}) : r2[CW-1:0];
            quo_reg  <= {quo_reg[SW-2:0], qbit};
            dcnt_reg <= dcnt_reg + DCW'(1);
        end
    end

    // Square root, two radicand bits per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            rop_reg  <= quo_reg[MEAN_W-1:0];
            rrem_reg <= '0;
            root_reg <= '0;
            rcnt_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            logic [17:0] rs;
            logic [17:0] t;
            rs = {rrem_reg[15:0], rop_reg[MEAN_W-1:MEAN_W-2]};
            t  = {root_reg, 2'b01};
            if (rs >= t)
            begin
                rrem_reg <= rs - t;
                root_reg <= {root_reg[14:0], 1'b1};
            end
            else
            begin
                rrem_reg <= rs;
                root_reg <= {root_reg[14:0], 1'b0};
            end
            rop_reg  <= {rop_reg[MEAN_W-3:0], 2'b00};
            rcnt_reg <= rcnt_reg + 4'd1;
        end
    end

    assign status.pend_pk   = pend_pk_reg;
    assign status.pend_lv   = pend_lv_reg;
    assign status.div_last  = (dcnt_reg == DCW'(SW - 1));
    assign status.sqrt_last = (rcnt_reg == 4'(ROOT_STEPS - 1));
    assign level            = cmd.sel_rms ? root_reg : peak_val_reg;

endmodule

// File: tb/sv/pcm_peak_rms_envelope_tb.sv
// Self-checking testbench for the PCM peak and RMS envelope follower.
module pcm_peak_rms_envelope_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import prenv_pkg::*;

    typedef struct packed {
        logic        op;
        logic [31:0] bits;
    } pcm_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] level;
        logic        last;
    } env_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    // High for one cycle after an input beat has been taken.
    logic        in_beat;

    pcm_peak_rms_envelope uut (.*);

    // Shadow of the block's registers and stream state.
    logic [1:0]  sh_format;
    logic [4:0]  sh_chans;
    logic [12:0] sh_pk_len;
    logic [12:0] sh_lv_len;
    int unsigned ch_idx;
    int unsigned frame_pk;
    int unsigned pk_frames;
    int unsigned chunk_pk;
    int unsigned lv_frames;
    longint unsigned sq_sum;

    pcm_item_t   pending_items[$];
    env_result_t expected_levels[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_sender = 0;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit q15_magnitude(input logic [31:0] b, output int unsigned mag);
        int unsigned e;
        int unsigned sh;
        int unsigned sig;
        logic [31:0] a;
        q15_magnitude = 1;
        case (sh_format)
            FMT_U8:  mag = (b[7:0] >= 128) ? (b[7:0] - 128) << 8 : (128 - b[7:0]) << 8;
            FMT_S16: mag = b[15] ? 32'h10000 - b[15:0] : b[15:0];
            FMT_S32:
            begin
                a = b[31] ? -b : b;
                mag = a >> 16;
            end
            default:
            begin
                e = b[30:23];
                sig = {1'b1, b[22:0]};
                if (e == 255) q15_magnitude = 0;
                else if (e == 0) mag = 0;
                else if (e >= 127) mag = 32768;
                else
                begin
                    sh = 135 - e;
                    mag = (sh >= 32) ? 0 : sig >> sh;
                end
            end
        endcase
    endfunction

    function automatic int unsigned int_sqrt(input longint unsigned v);
        longint unsigned res = 0;
        longint unsigned bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end
            else res >>= 1;
            bt >>= 2;
        end
        return 32'(res);
    endfunction

    function automatic int unsigned rms_of_chunk();
        return lv_frames == 0 ? 0 : int_sqrt(sq_sum / lv_frames);
    endfunction

    function automatic void clear_stream();
        ch_idx = 0; frame_pk = 0; pk_frames = 0; chunk_pk = 0; lv_frames = 0; sq_sum = 0;
    endfunction

    function automatic void predict_envelope(input pcm_item_t it);
        env_result_t r[$];
        int unsigned chans;
        int unsigned pk;
        int unsigned lv;
        int unsigned mag;
        int unsigned fp;
        if (it.op == OP_FINISH)
        begin
            if (pk_frames > 0) r.push_back('{KIND_PEAK, chunk_pk[15:0], 1'b0});
            if (lv_frames > 0) r.push_back('{KIND_RMS, 16'(rms_of_chunk()), 1'b0});
            clear_stream();
        end
        else
        begin
            chans = sh_chans < 1 ? 1 : (sh_chans > 16 ? 16 : sh_chans);
            pk = sh_pk_len < 1 ? 1 : (sh_pk_len > 4096 ? 4096 : sh_pk_len);
            lv = sh_lv_len < 64 ? 64 : (sh_lv_len > 4096 ? 4096 : sh_lv_len);
            if (q15_magnitude(it.bits, mag) && mag > frame_pk) frame_pk = mag;
            ch_idx++;
            if (ch_idx >= chans)
            begin
                fp = frame_pk;
                ch_idx = 0;
                frame_pk = 0;
                if (fp > chunk_pk) chunk_pk = fp;
                pk_frames++;
                if (pk_frames >= pk)
                begin
                    r.push_back('{KIND_PEAK, chunk_pk[15:0], 1'b0});
                    pk_frames = 0;
                    chunk_pk = 0;
                end
                sq_sum += longint'(fp) * fp;
                lv_frames++;
                if (lv_frames >= lv)
                begin
                    r.push_back('{KIND_RMS, 16'(rms_of_chunk()), 1'b0});
                    lv_frames = 0;
                    sq_sum = 0;
                end
            end
        end
        if (r.size() > 0) r[r.size() - 1].last = 1'b1;
        foreach (r[i]) expected_levels.push_back(r[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) in_beat <= 1'b0;
        else in_beat <= s_tvalid && s_tready;
    end

    // Sample driver: changes on the falling edge, accepted on the rising edge.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else if (!s_tvalid || in_beat)
        begin
            if (pending_items.size() > 0 && !hold_sender &&
                $urandom_range(99, 0) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_items[0].op;
                s_tdata  <= pending_items[0].bits;
                void'(pending_items.pop_front());
            end
            else s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready) predict_envelope('{s_tuser, s_tdata});
    end

    always @(posedge clk)
    begin
        env_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_levels.size() == 0)
            begin
                $display("%0t unexpected beat kind=%0d level=%0d last=%0d",
                         $time, m_tuser, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = expected_levels.pop_front();
                if (want.kind !== m_tuser || want.level !== m_tdata || want.last !== m_tlast)
                begin
                    $display("%0t mismatch expected kind=%0d level=%0d last=%0d, got %0d %0d %0d",
                             $time, want.kind, want.level, want.last, m_tuser, m_tdata, m_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FORMAT:   sh_format = val[1:0];
            REG_CHANNELS: sh_chans  = val[4:0];
            REG_PEAK_LEN: sh_pk_len = val;
            default:      sh_lv_len = val;
        endcase
    endtask

    task automatic drain_and_settle();
        while (pending_items.size() > 0 || s_tvalid || expected_levels.size() > 0)
            @(posedge clk);
        // A sample that closes no chunk may still be in the block when the loop ends.
        repeat (120) @(posedge clk);
    endtask

    function automatic logic [31:0] random_bits();
        logic [31:0] b = $urandom();
        case ($urandom_range(7, 0))
            0: b = 32'h3F80_0000 | (b & 32'h8000_0000);   // float +-1.0
            1: b = {b[31], 8'hFF, b[22:0]};               // non-finite float
            2: b = {b[31], 8'h00, b[22:0]};               // denormal
            3: b = {b[31], 8'(113 + $urandom_range(14, 0)), b[22:0]};
            default: ;
        endcase
        return b;
    endfunction

    task automatic random_phase(input int count);
        repeat (count)
        begin
            if ($urandom_range(79, 0) == 0) pending_items.push_back('{OP_FINISH, $urandom()});
            else pending_items.push_back('{OP_SAMPLE, random_bits()});
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_FORMAT;
        cfg_data = '0;
        sh_format = RST_FORMAT;
        sh_chans = RST_CHANNELS;
        sh_pk_len = RST_PEAK_LEN;
        sh_lv_len = RST_RMS_LEN;
        clear_stream();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part with reset settings, then unsigned 8-bit, signed 32-bit and float extremes.
        pending_items.push_back('{OP_SAMPLE, 32'hFFFF_8000});
        pending_items.push_back('{OP_SAMPLE, 32'h0000_7FFF});
        pending_items.push_back('{OP_SAMPLE, 32'h0000_0001});
        pending_items.push_back('{OP_FINISH, 32'h0});
        pending_items.push_back('{OP_FINISH, 32'hFFFF_FFFF});
        drain_and_settle();
        write_reg(REG_FORMAT, FMT_U8);
        write_reg(REG_CHANNELS, 13'd1);
        write_reg(REG_PEAK_LEN, 13'd1);
        write_reg(REG_RMS_LEN, 13'd64);
        pending_items.push_back('{OP_SAMPLE, 32'hFFFF_FF00});
        pending_items.push_back('{OP_SAMPLE, 32'h0000_00FF});
        pending_items.push_back('{OP_SAMPLE, 32'h0000_0080});
        drain_and_settle();
        write_reg(REG_FORMAT, FMT_S32);
        pending_items.push_back('{OP_SAMPLE, 32'h8000_0000});
        pending_items.push_back('{OP_SAMPLE, 32'h7FFF_FFFF});
        pending_items.push_back('{OP_SAMPLE, 32'h0000_FFFF});
        drain_and_settle();
        write_reg(REG_FORMAT, FMT_F32);
        pending_items.push_back('{OP_SAMPLE, 32'h3F80_0000});
        pending_items.push_back('{OP_SAMPLE, 32'hBF7F_FFFF});
        pending_items.push_back('{OP_SAMPLE, 32'h7F80_0000});
        pending_items.push_back('{OP_SAMPLE, 32'hFFC0_0001});
        pending_items.push_back('{OP_SAMPLE, 32'h0000_0001});
        pending_items.push_back('{OP_SAMPLE, 32'h3800_0000});
        pending_items.push_back('{OP_SAMPLE, 32'h4F00_0000});
        pending_items.push_back('{OP_FINISH, 32'h0});
        drain_and_settle();

        // Random phases over several settings, out-of-range register values among them.
        send_idle_pct = 38; recv_idle_pct = 77;
        write_reg(REG_CHANNELS, 13'd0);
        write_reg(REG_PEAK_LEN, 13'd0);
        write_reg(REG_RMS_LEN, 13'd0);
        random_phase(150);
        drain_and_settle();
        write_reg(REG_FORMAT, FMT_S16);
        write_reg(REG_CHANNELS, 13'd31);
        write_reg(REG_PEAK_LEN, 13'd3);
        write_reg(REG_RMS_LEN, 13'd64);
        random_phase(200);
        // Pause until every expected beat has come, then carry on mid-stream.
        while (pending_items.size() > 0 || s_tvalid) @(posedge clk);
        hold_sender = 1;
        while (expected_levels.size() > 0) @(posedge clk);
        hold_sender = 0;
        random_phase(30);
        drain_and_settle();

        send_idle_pct = 77; recv_idle_pct = 38;
        write_reg(REG_FORMAT, FMT_F32);
        write_reg(REG_CHANNELS, 13'd2);
        write_reg(REG_PEAK_LEN, 13'h1FFF);
        write_reg(REG_RMS_LEN, 13'h1FFF);
        random_phase(120);
        drain_and_settle();
        write_reg(REG_FORMAT, FMT_U8);
        write_reg(REG_CHANNELS, 13'd16);
        write_reg(REG_PEAK_LEN, 13'd4096);
        write_reg(REG_RMS_LEN, 13'd4096);
        random_phase(100);
        drain_and_settle();

        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(REG_FORMAT, FMT_S32);
        write_reg(REG_CHANNELS, 13'd1);
        write_reg(REG_PEAK_LEN, 13'd5);
        write_reg(REG_RMS_LEN, 13'd70);
        random_phase(250);
        drain_and_settle();
        write_reg(REG_FORMAT, FMT_F32);
        write_reg(REG_CHANNELS, 13'd3);
        write_reg(REG_PEAK_LEN, 13'd2);
        write_reg(REG_RMS_LEN, 13'd64);
        random_phase(200);
        pending_items.push_back('{OP_FINISH, 32'h0});
        drain_and_settle();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
